### rtl/core/alarm_timer_bank_top_defines.svh
// Assertion macros for the checker file of the alarm timer bank.
`ifndef ALARM_TIMER_BANK_TOP_DEFINES_SVH
`define ALARM_TIMER_BANK_TOP_DEFINES_SVH

// Checked only while out of reset.
`define ATB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ATB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/atb_pkg.sv
`default_nettype none

package atb_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int DELAY_BITS  = 24;
  localparam int SLOT_IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NOW_BITS    = 32;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/alarm_timer_bank_top.sv
// Bank of alarm slots driven by a millisecond tick.
// Input channel (in_valid/in_ready): one command item with in_cmd, in_slot,
// in_delay_ms and in_periodic. A set or restart item is taken while the block
// is idle and leaves it ready. A tick item advances the millisecond counter
// and then compares one slot per cycle in a shared subtract/compare unit;
// in_ready stays low through the scan pass over all slots and the emit pass.
// Result channel (out_valid/out_ready): one item per fired slot, in slot order,
// with out_last set on the final one of the tick. A tick with no fired slot
// gives no item. Results sit in an output register; when the receiver stalls
// the emit pass waits on that register and the block stays busy, while an
// idle block still takes set and restart items with a result pending.
// Reset clears the counter, all active flags and the output valid flag; the
// block is ready in the first cycle after reset.
`default_nettype none

module alarm_timer_bank_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [2:0]                    in_slot,
  input  wire logic [23:0]                   in_delay_ms,
  input  wire logic                          in_periodic,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_fired_slot,
  output logic                               out_fired_periodic,
  output logic                               out_last
);
  import atb_pkg::*;

  state_t                  state_r, state_nxt;
  logic [SLOT_IW-1:0]      idx_r, idx_nxt;
  logic [NOW_BITS-1:0]     now_r, now_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_slot_r;
  logic                    out_per_r;
  logic                    out_last_r;

  logic [DELAY_BITS-1:0]   delay_r [NUM_SLOTS];
  logic [NOW_BITS-1:0]     start_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    per_r;
  logic [NUM_SLOTS-1:0]    active_r;
  logic [NUM_SLOTS-1:0]    mask_r;

  logic                    in_acc;
  logic                    slot_ok;
  logic                    tick_acc, set_acc, restart_acc;
  logic [NOW_BITS-1:0]     elapsed;
  logic                    fire;
  logic                    idx_end;
  logic                    load;
  logic                    advance;
  logic [NUM_SLOTS-1:0]    rest;

  assign in_acc      = in_valid && in_ready;
  assign slot_ok     = int'(in_slot) < NUM_SLOTS;
  assign tick_acc    = in_acc && (cmd_t'(in_cmd) == CMD_TICK);
  assign set_acc     = in_acc && (cmd_t'(in_cmd) == CMD_SET) && slot_ok;
  assign restart_acc = in_acc && (cmd_t'(in_cmd) == CMD_RESTART) && slot_ok;

  // Shared compare unit: wrapped elapsed time against the slot delay.
  assign elapsed = now_r - start_r[idx_r];
  assign fire    = active_r[idx_r] && (elapsed >= NOW_BITS'(delay_r[idx_r]));
  assign idx_end = (int'(idx_r) == NUM_SLOTS - 1);

  // A result is last when no higher slot fired on this tick.
  assign rest    = mask_r >> idx_r;
  assign load    = (state_r == ST_EMIT) && mask_r[idx_r] && (!out_valid_r || out_ready);
  assign advance = (state_r == ST_EMIT) && (!mask_r[idx_r] || load);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance && idx_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r;
    if (tick_acc) begin
      now_nxt = now_r + 1'b1;
      idx_nxt = '0;
    end
    if (state_r == ST_SCAN || advance) begin
      idx_nxt = idx_end ? '0 : idx_r + 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      active_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      if (set_acc) begin
        active_r[in_slot[SLOT_IW-1:0]] <= (in_delay_ms[DELAY_BITS-1:0] != '0);
      end
      if (state_r == ST_SCAN && fire && !per_r[idx_r]) begin
        active_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_acc) begin
      delay_r[in_slot[SLOT_IW-1:0]] <= in_delay_ms[DELAY_BITS-1:0];
      per_r[in_slot[SLOT_IW-1:0]]   <= in_periodic;
      start_r[in_slot[SLOT_IW-1:0]] <= now_r;
    end
    if (restart_acc) begin
      start_r[in_slot[SLOT_IW-1:0]] <= now_r;
    end
    if (state_r == ST_SCAN) begin
      mask_r[idx_r] <= fire;
      if (fire && per_r[idx_r]) begin
        start_r[idx_r] <= now_r;
      end
    end
    if (load) begin
      out_slot_r <= 3'(idx_r);
      out_per_r  <= per_r[idx_r];
      out_last_r <= ((rest >> 1) == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fired_slot     = out_slot_r;
  assign out_fired_periodic = out_per_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

### rtl/core/atb_checker.sv
`default_nettype none

`include "alarm_timer_bank_top_defines.svh"

module atb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_fired_slot,
  input wire logic       out_fired_periodic,
  input wire logic       out_last
);
  import atb_pkg::*;

  `ATB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_fired_slot) && $stable(out_fired_periodic) && $stable(out_last), "result changed while stalled")
  `ATB_ASSERT(a_tick_busy, in_valid && in_ready && (in_cmd == CMD_TICK) |=> !in_ready, "block ready right after a tick")
  `ATB_ASSERT(a_cmd_quick, in_valid && in_ready && (in_cmd != CMD_TICK) |=> in_ready, "block busy after a non-tick command")
  `ATB_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_valid && in_ready, "wrong state after reset")

endmodule

bind alarm_timer_bank_top atb_checker u_atb_checker (.*);

`default_nettype wire
